[sv/avm_pkg.sv]
`default_nettype none

package avm_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_BATCH  = 2'd0,
    KIND_SERIAL = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  // Result item kinds
  typedef enum logic {
    OUT_SERIAL  = 1'b0,
    OUT_DISPLAY = 1'b1
  } out_kind_e;

  localparam int unsigned SampleW = 10;
  localparam int unsigned TenthsW = 6;
  localparam int unsigned BeatW   = 2;

  localparam logic [TenthsW-1:0] FullTenths = 6'd33;
  localparam logic [BeatW-1:0]   BeatLast   = 2'd3;

  // Reply beats
  localparam logic [BeatW-1:0] BeatTens  = 2'd0;
  localparam logic [BeatW-1:0] BeatPoint = 2'd1;
  localparam logic [BeatW-1:0] BeatUnits = 2'd2;

  localparam logic [7:0] CharMax   = 8'h4D;  // 'M'
  localparam logic [7:0] CharMin   = 8'h6D;  // 'm'
  localparam logic [7:0] CharPoint = 8'h2E;  // '.'
  localparam logic [7:0] CharVolt  = 8'h56;  // 'V'
  localparam logic [7:0] CharZero  = 8'h30;

  // One result job handed from the core stage to the output stage
  typedef struct packed {
    logic       disp;
    logic [3:0] tens;
    logic [3:0] units;
    logic       digit_high;
    logic [6:0] seg;
  } avm_job_t;

  // x / 1023 for x < 2046*1024: estimate x>>10, remainder below 2*1023
  function automatic logic [TenthsW-1:0] div_1023(input logic [15:0] x);
    logic [5:0]  q;
    logic [10:0] r;
    begin
      q = x[15:10];
      r = {1'b0, x[9:0]} + {5'd0, q};
      if (r >= 11'd1023) begin
        q = q + 6'd1;
      end
      return q;
    end
  endfunction

  function automatic logic [3:0] tens_of(input logic [TenthsW-1:0] v);
    logic [3:0] t;
    begin
      if (v >= 6'd60)      t = 4'd6;
      else if (v >= 6'd50) t = 4'd5;
      else if (v >= 6'd40) t = 4'd4;
      else if (v >= 6'd30) t = 4'd3;
      else if (v >= 6'd20) t = 4'd2;
      else if (v >= 6'd10) t = 4'd1;
      else                 t = 4'd0;
      return t;
    end
  endfunction

  function automatic logic [3:0] units_of(input logic [TenthsW-1:0] v);
    logic [6:0] tens10;
    logic [6:0] diff;
    begin
      tens10 = {3'd0, tens_of(v)} * 7'd10;
      diff   = {1'b0, v} - tens10;
      return diff[3:0];
    end
  endfunction

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    begin
      case (d)
        4'd0:    s = 7'h3F;
        4'd1:    s = 7'h06;
        4'd2:    s = 7'h5B;
        4'd3:    s = 7'h4F;
        4'd4:    s = 7'h66;
        4'd5:    s = 7'h6D;
        4'd6:    s = 7'h7D;
        4'd7:    s = 7'h07;
        4'd8:    s = 7'h7F;
        4'd9:    s = 7'h6F;
        default: s = 7'h00;
      endcase
      return s;
    end
  endfunction

endpackage

`default_nettype wire

[sv/avm_core.sv]
`default_nettype none

// Measurement state and per-item decode, fed from the input register
module avm_core import avm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,     // item in input register moves on
  input  wire logic [1:0]         kind_i,
  input  wire logic [SampleW-1:0] sample_a_i,
  input  wire logic [SampleW-1:0] sample_b_i,
  input  wire logic [SampleW-1:0] sample_c_i,
  input  wire logic [SampleW-1:0] sample_d_i,
  input  wire logic [7:0]         rx_char_i,
  output logic                    job_vld_o,  // item yields results
  output avm_job_t                job_o
);

  logic [TenthsW-1:0] reading_q, reading_d;
  logic [TenthsW-1:0] lowest_q, lowest_d;
  logic [TenthsW-1:0] highest_q, highest_d;
  logic               toggle_q, toggle_d;

  logic [11:0]        sum;
  logic [15:0]        scaled;
  logic [TenthsW-1:0] new_reading;
  logic [TenthsW-1:0] reply_val;
  logic [3:0]         disp_digit;

  always_comb begin
    sum         = {2'd0, sample_a_i} + {2'd0, sample_b_i}
                + {2'd0, sample_c_i} + {2'd0, sample_d_i};
    scaled      = {6'd0, sum[11:2]} * 16'd33 + 16'd511;
    new_reading = div_1023(scaled);
    disp_digit  = toggle_q ? tens_of(reading_q) : units_of(reading_q);
  end

  always_comb begin
    reading_d = reading_q;
    lowest_d  = lowest_q;
    highest_d = highest_q;
    toggle_d  = toggle_q;
    job_vld_o = 1'b0;
    reply_val = highest_q;
    job_o     = '0;
    case (kind_e'(kind_i))
      KIND_BATCH: begin
        reading_d = new_reading;
        if (new_reading > highest_q) highest_d = new_reading;
        if (new_reading < lowest_q)  lowest_d  = new_reading;
      end
      KIND_SERIAL: begin
        if (rx_char_i == CharMax) begin
          job_vld_o = 1'b1;
          reply_val = highest_q;
        end else if (rx_char_i == CharMin) begin
          job_vld_o = 1'b1;
          reply_val = lowest_q;
        end
        job_o.disp  = 1'b0;
        job_o.tens  = tens_of(reply_val);
        job_o.units = units_of(reply_val);
      end
      KIND_TICK: begin
        job_vld_o        = 1'b1;
        job_o.disp       = 1'b1;
        job_o.digit_high = toggle_q;
        job_o.seg        = seg_of(disp_digit);
        toggle_d         = ~toggle_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reading_q <= '0;
      lowest_q  <= FullTenths;
      highest_q <= '0;
      toggle_q  <= 1'b0;
    end else if (adv_i) begin
      reading_q <= reading_d;
      lowest_q  <= lowest_d;
      highest_q <= highest_d;
      toggle_q  <= toggle_d;
    end
  end

endmodule

`default_nettype wire

[sv/avm_out.sv]
`default_nettype none

// Result register: holds one job and plays it out as one or four items
module avm_out import avm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire avm_job_t job_i,
  output logic          free_o,    // can take a job this cycle
  output logic          tvalid_o,
  input  wire logic     tready_i,
  output logic [15:0]   tdata_o,
  output logic          tuser_o,
  output logic          tlast_o
);

  logic               vld_q, vld_d;
  logic [BeatW-1:0]   beat_q, beat_d;
  avm_job_t           job_q;
  logic [7:0]         tx_char;
  logic               fire;

  always_comb begin
    case (beat_q)
      BeatTens:  tx_char = CharZero + {4'd0, job_q.tens};
      BeatPoint: tx_char = CharPoint;
      BeatUnits: tx_char = CharZero + {4'd0, job_q.units};
      default:   tx_char = CharVolt;
    endcase
  end

  always_comb begin
    tvalid_o = vld_q;
    tlast_o  = job_q.disp || (beat_q == BeatLast);
    fire     = vld_q && tready_i;
    free_o   = !vld_q || (fire && tlast_o);
    if (job_q.disp) begin
      tuser_o = OUT_DISPLAY;
      tdata_o = {job_q.seg, job_q.digit_high, 8'd0};
    end else begin
      tuser_o = OUT_SERIAL;
      tdata_o = {8'd0, tx_char};
    end
  end

  always_comb begin
    vld_d  = vld_q;
    beat_d = beat_q;
    if (load_i) begin
      vld_d  = 1'b1;
      beat_d = BeatTens;
    end else if (fire) begin
      if (tlast_o) vld_d = 1'b0;
      else         beat_d = beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beat_q <= BeatTens;
    end else begin
      vld_q  <= vld_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) job_q <= job_i;
  end

endmodule

`default_nettype wire

[sv/averaging_voltmeter_min_max.sv]
`default_nettype none

// Averaging voltmeter with running min/max. A batch item (tuser 0) brings four
// 10-bit samples; their mean is scaled to tenths of a volt (0..33, rounded) and
// becomes the current reading, and the running minimum and maximum follow it.
// Batches give no output. A serial item (tuser 1) carrying 'M' or 'm' answers
// with four bytes "d.dV" of the maximum or minimum (minimum reads 3.3V until
// the first batch); other characters are dropped. A display tick (tuser 2)
// gives one item with the digit select and seven-segment code of the current
// reading, units digit first, then alternating. Tuser 3 is ignored.
// Timing: an item passes an input register and then a result register before
// its first result can be taken. Batches go at one item per cycle, and ticks
// too while the result register is free; a serial reply holds the result
// register for four output beats, so a following item that has results waits
// until the last byte 'V' is taken, while a batch or a dropped item behind it
// still passes.

module averaging_voltmeter_min_max import avm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [9:0] sample_a, [19:10] sample_b, [29:20] sample_c, [39:30] sample_d,
  // [47:40] rx_char
  input  wire logic [47:0] s_axis_tdata_i,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] tx_char, [8] digit_high, [15:9] segments
  output logic [15:0]      m_axis_tdata_o,
  // [0] out_kind
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  // Input register
  logic        in_vld_q;
  logic [47:0] in_data_q;
  logic [1:0]  in_kind_q;

  logic     adv;
  logic     job_vld;
  avm_job_t job;
  logic     out_free;

  // Item leaves the input register when it has no results or the
  // result register can take its job.
  assign adv             = in_vld_q && (!job_vld || out_free);
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_kind_q <= s_axis_tuser_i;
    end
  end

  avm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .kind_i     (in_kind_q),
    .sample_a_i (in_data_q[9:0]),
    .sample_b_i (in_data_q[19:10]),
    .sample_c_i (in_data_q[29:20]),
    .sample_d_i (in_data_q[39:30]),
    .rx_char_i  (in_data_q[47:40]),
    .job_vld_o  (job_vld),
    .job_o      (job)
  );

  avm_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv && job_vld),
    .job_i    (job),
    .free_o   (out_free),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .tdata_o  (m_axis_tdata_o),
    .tuser_o  (m_axis_tuser_o),
    .tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire
